// ===== sv/sasf_pkg.sv =====
// Package for the scale ASCII frame decoder.
// Holds character codes, frame positions, status code enums and the item structs.
// No dependencies.
package sasf_pkg;

  // Character codes
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_U    = 8'h55;
  localparam logic [7:0] CH_O    = 8'h4F;
  localparam logic [7:0] CH_L    = 8'h4C;
  localparam logic [7:0] CH_N    = 8'h4E;
  localparam logic [7:0] CH_G    = 8'h47;

  // Frame positions
  localparam int unsigned POS_W = 5;
  localparam logic [POS_W-1:0] POS_STAB0      = 5'd0;
  localparam logic [POS_W-1:0] POS_STAB1      = 5'd1;
  localparam logic [POS_W-1:0] POS_MODE0      = 5'd3;
  localparam logic [POS_W-1:0] POS_MODE1      = 5'd4;
  localparam logic [POS_W-1:0] POS_LAST_DIGIT = 5'd11;
  localparam logic [POS_W-1:0] POS_CR         = 5'd14;
  localparam logic [POS_W-1:0] POS_LF         = 5'd15;
  localparam logic [POS_W-1:0] POS_IDLE       = 5'd16;

  // Status codes
  typedef enum logic [1:0] {
    STAB_ST      = 2'd0,
    STAB_US      = 2'd1,
    STAB_OL      = 2'd2,
    STAB_UNKNOWN = 2'd3
  } stability_t;

  typedef enum logic [1:0] {
    MODE_NT      = 2'd0,
    MODE_GS      = 2'd1,
    MODE_UNKNOWN = 2'd2
  } weigh_mode_t;

  // One received byte
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } byte_item_t;

  // One decoded frame result
  typedef struct packed {
    logic [31:0] reading;
    logic [31:0] previous_reading;
    stability_t  stability_code;
    weigh_mode_t weigh_mode;
    logic        frame_ok;
  } result_t;

endpackage

// ===== sv/sasf_if.sv =====
// Valid/ready channel interfaces of the scale ASCII frame decoder.
// Depends on nothing; payload widths follow the frame format.
interface sasf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface sasf_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] reading;
  logic [31:0] previous_reading;
  logic [1:0]  stability_code;
  logic [1:0]  weigh_mode;
  logic        frame_ok;

  modport source (output valid, output reading, output previous_reading,
                  output stability_code, output weigh_mode, output frame_ok,
                  input ready);
  modport sink   (input valid, input reading, input previous_reading,
                  input stability_code, input weigh_mode, input frame_ok,
                  output ready);
endinterface

// ===== sv/sasf_input_stage.sv =====
// Input register of the scale ASCII frame decoder.
// Depends on sasf_pkg (byte_item_t).
module sasf_input_stage
  import sasf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  byte_item_t in_item,
  output logic       in_ready,
  input  logic       advance,
  output logic       valid,
  output byte_item_t item
);

  // Take a new byte when empty or when the held one moves on this cycle
  assign in_ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

// ===== sv/sasf_frame_core.sv =====
// Frame state and per-byte decode of the scale ASCII frame decoder.
// Depends on sasf_pkg (codes, positions, structs).
module sasf_frame_core
  import sasf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  byte_item_t item,
  output logic       emit,
  output result_t    result
);

  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] byte_position_next;
  logic [31:0]      digit_accumulator;
  logic [31:0]      digit_accumulator_next;
  logic             cr_seen;
  logic             cr_seen_next;
  logic [31:0]      pressure_reading;
  stability_t       stability_state;
  weigh_mode_t      mode_state;
  logic [7:0]       hdr_stab0;
  logic [7:0]       hdr_stab1;
  logic [7:0]       hdr_mode0;
  logic [7:0]       hdr_mode1;

  logic [POS_W-1:0] pos;
  logic [31:0]      acc_base;
  logic             cr_base;
  logic [31:0]      digit;
  logic             ok;
  stability_t       stab_dec;
  weigh_mode_t      mode_dec;

  function automatic stability_t decode_stability(logic [7:0] a, logic [7:0] b);
    if (a == CH_S && b == CH_T) return STAB_ST;
    if (a == CH_U && b == CH_S) return STAB_US;
    if (a == CH_O && b == CH_L) return STAB_OL;
    return STAB_UNKNOWN;
  endfunction

  function automatic weigh_mode_t decode_mode(logic [7:0] a, logic [7:0] b);
    if (a == CH_N && b == CH_T) return MODE_NT;
    if (a == CH_G && b == CH_S) return MODE_GS;
    return MODE_UNKNOWN;
  endfunction

  // Effective position and cleared state at frame start
  always_comb begin
    pos      = item.frame_start ? POS_STAB0 : byte_position;
    acc_base = (pos == POS_STAB0) ? 32'd0 : digit_accumulator;
    cr_base  = (pos == POS_STAB0) ? 1'b0 : cr_seen;
    digit    = {24'd0, item.rx_byte - CH_ZERO};
  end

  // Next position, accumulator and CR flag
  always_comb begin
    byte_position_next     = (pos >= POS_IDLE) ? POS_IDLE : pos + 1'b1;
    digit_accumulator_next = acc_base;
    cr_seen_next           = cr_base;
    if (pos <= POS_LAST_DIGIT) begin
      if (item.rx_byte == CH_SP) begin
        digit_accumulator_next = 32'd0;
      end else begin
        // acc*10 as two shifts and an add, wraps mod 2^32
        digit_accumulator_next = (acc_base << 3) + (acc_base << 1) + digit;
      end
    end
    if (pos == POS_CR) begin
      cr_seen_next = (item.rx_byte == CH_CR);
    end
  end

  // Result of the frame on its last byte
  always_comb begin
    emit     = (pos == POS_LF);
    ok       = cr_base && (item.rx_byte == CH_LF);
    stab_dec = decode_stability(hdr_stab0, hdr_stab1);
    mode_dec = decode_mode(hdr_mode0, hdr_mode1);
    result.previous_reading = pressure_reading;
    result.frame_ok         = ok;
    result.reading          = ok ? acc_base : pressure_reading;
    result.stability_code   = ok ? stab_dec : stability_state;
    result.weigh_mode       = ok ? mode_dec : mode_state;
  end

  // Control and stored readings
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= POS_STAB0;
      digit_accumulator <= 32'd0;
      cr_seen           <= 1'b0;
      pressure_reading  <= 32'd0;
      stability_state   <= STAB_UNKNOWN;
      mode_state        <= MODE_UNKNOWN;
    end else if (take) begin
      byte_position <= byte_position_next;
      if (pos < POS_IDLE) begin
        digit_accumulator <= digit_accumulator_next;
        cr_seen           <= cr_seen_next;
      end else begin
        digit_accumulator <= acc_base;
        cr_seen           <= cr_base;
      end
      if (emit && ok) begin
        pressure_reading <= result.reading;
        stability_state  <= result.stability_code;
        mode_state       <= result.weigh_mode;
      end
    end
  end

  // Header bytes, written before the frame end reads them
  always_ff @(posedge clk) begin
    if (take) begin
      if (pos == POS_STAB0) hdr_stab0 <= item.rx_byte;
      if (pos == POS_STAB1) hdr_stab1 <= item.rx_byte;
      if (pos == POS_MODE0) hdr_mode0 <= item.rx_byte;
      if (pos == POS_MODE1) hdr_mode1 <= item.rx_byte;
    end
  end

endmodule

// ===== sv/sasf_result_reg.sv =====
// Output register of the scale ASCII frame decoder.
// Depends on sasf_pkg (result_t).
module sasf_result_reg
  import sasf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_result,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t out_result
);

  // Valid holds until the transaction completes or is replaced
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_result <= load_result;
    end
  end

endmodule

// ===== sv/scale_ascii_frame_decoder.sv =====
// Top level of the scale ASCII frame decoder.
// Depends on sasf_pkg, sasf_if, sasf_input_stage, sasf_frame_core, sasf_result_reg.
//
// Usage:
//   bytes   : sink channel, one frame byte per transaction (rx_byte, frame_start).
//             frame_start marks position 0 and restarts the frame at any point.
//   results : source channel, one transaction per frame, produced on byte 15:
//             reading, previous_reading, stability_code, weigh_mode, frame_ok.
//   Bytes after position 15 are dropped until the next frame_start.
// Throughput: one byte per cycle while no result is stalled. Each byte is
//   registered at the input, then decoded by the frame logic and, on byte
//   15, written to the output register.
// Reset (rst, synchronous): position and accumulator clear, stored reading 0,
//   stability unknown, mode unknown; both channels empty.
// Stall: while a result waits, bytes keep flowing until the next frame end
//   reaches the frame logic; that byte then waits in the input register and
//   bytes.ready drops until results.ready takes the pending result.
module scale_ascii_frame_decoder
  import sasf_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  sasf_byte_if.sink     bytes,
  sasf_result_if.source results
);

  byte_item_t in_item;
  byte_item_t s1_item;
  logic       s1_valid;
  logic       advance;
  logic       emit;
  result_t    core_result;
  result_t    out_result;
  logic       out_valid;

  assign in_item.rx_byte     = bytes.rx_byte;
  assign in_item.frame_start = bytes.frame_start;

  // A held byte moves on unless it makes a result with no room for it
  assign advance = s1_valid && (!emit || !out_valid || results.ready);

  sasf_input_stage u_input (
    .clk      (clk),
    .rst      (rst),
    .in_valid (bytes.valid),
    .in_item  (in_item),
    .in_ready (bytes.ready),
    .advance  (advance),
    .valid    (s1_valid),
    .item     (s1_item)
  );

  sasf_frame_core u_core (
    .clk    (clk),
    .rst    (rst),
    .take   (advance),
    .item   (s1_item),
    .emit   (emit),
    .result (core_result)
  );

  sasf_result_reg u_result (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && emit),
    .load_result (core_result),
    .out_ready   (results.ready),
    .out_valid   (out_valid),
    .out_result  (out_result)
  );

  assign results.valid            = out_valid;
  assign results.reading          = out_result.reading;
  assign results.previous_reading = out_result.previous_reading;
  assign results.stability_code   = out_result.stability_code;
  assign results.weigh_mode       = out_result.weigh_mode;
  assign results.frame_ok         = out_result.frame_ok;

endmodule

// ===== sv/sasf_checker.sv =====
// Port-level checks for the scale ASCII frame decoder, bound to the top level.
// Depends on sasf_pkg (mode codes) and the top level's channel ports.
module sasf_checker
  import sasf_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] reading,
  input logic [31:0] previous_reading,
  input logic [1:0]  weigh_mode,
  input logic        frame_ok
);

  // No result and free input right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("channels not empty after reset");

  // A stalled result keeps its value
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(reading) && $stable(frame_ok)))
    else $error("stalled result changed");

  // A bad terminator leaves the stored reading unchanged
  a_bad_frame_keeps: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !frame_ok) |-> (reading == previous_reading))
    else $error("bad frame changed the reading");

  // Input only stalls while a result is pending
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_ready) |-> out_valid)
    else $error("input stalled with no pending result");

  // Mode code three is never produced
  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (weigh_mode == MODE_NT || weigh_mode == MODE_GS ||
                   weigh_mode == MODE_UNKNOWN))
    else $error("weigh mode out of range");

endmodule

bind scale_ascii_frame_decoder sasf_checker u_sasf_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (bytes.valid),
  .in_ready         (bytes.ready),
  .out_valid        (results.valid),
  .out_ready        (results.ready),
  .reading          (results.reading),
  .previous_reading (results.previous_reading),
  .weigh_mode       (results.weigh_mode),
  .frame_ok         (results.frame_ok)
);
